/* src/mcs_pkg.sv */
package mcs_pkg;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_OK      = 3'd1;
    localparam logic [2:0] EV_TIMEOUT = 3'd2;
    localparam logic [2:0] EV_MSG     = 3'd3;
    localparam logic [2:0] EV_KNOWN   = 3'd4;
    localparam logic [2:0] EV_UNKNOWN = 3'd5;
    localparam logic [2:0] EV_READY   = 3'd6;
    localparam logic [2:0] EV_ERROR   = 3'd7;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_CONFIG = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_SEND   = 2'd3;

    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_READ    = 4'd9;
    localparam logic [3:0] CMD_DELETE  = 4'd10;
    localparam logic [3:0] CMD_ADDRESS = 4'd11;
    localparam logic [3:0] CMD_PAYLOAD = 4'd12;

    localparam logic [1:0] T_NONE  = 2'd0;
    localparam logic [1:0] T_START = 2'd1;
    localparam logic [1:0] T_STOP  = 2'd2;

    localparam logic [3:0] REP_NONE       = 4'd0;
    localparam logic [3:0] REP_ECHO       = 4'd1;
    localparam logic [3:0] REP_AT         = 4'd2;
    localparam logic [3:0] REP_SIM        = 4'd3;
    localparam logic [3:0] REP_CALLERID   = 4'd4;
    localparam logic [3:0] REP_CLEARED    = 4'd5;
    localparam logic [3:0] REP_CONFIGURED = 4'd6;
    localparam logic [3:0] REP_DELETED    = 4'd7;
    localparam logic [3:0] REP_SENT       = 4'd8;
    localparam logic [3:0] REP_NOTSENT    = 4'd9;

    localparam logic [15:0] REPLY_TMO_RST   = 16'd2000;
    localparam logic [15:0] PAYLOAD_TMO_RST = 16'd5000;
    localparam logic [2:0]  CMD_LIMIT_RST   = 3'd5;
    localparam logic [2:0]  PAY_LIMIT_RST   = 3'd3;

    typedef enum logic [1:0] {
        REG_REPLY_TMO   = 2'd0,
        REG_PAYLOAD_TMO = 2'd1,
        REG_CMD_LIMIT   = 2'd2,
        REG_PAY_LIMIT   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] reply_tmo;
        logic [15:0] payload_tmo;
        logic [2:0]  cmd_limit;
        logic [2:0]  pay_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  event_req;
        logic        send_pending;
        logic [15:0] message_handle;
        logic [7:0]  sms_index;
    } item_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  issued_command;
        logic [7:0]  command_index;
        logic [15:0] payload_handle;
        logic [1:0]  timer_action;
        logic [15:0] timer_ms;
        logic [3:0]  report;
        logic        send_taken;
        logic        configured;
    } result_t;

    function automatic logic [3:0] cfg_report(input logic [2:0] k);
        logic [3:0] r;
        unique case (k)
            3'd0:    r = REP_ECHO;
            3'd1:    r = REP_AT;
            3'd2:    r = REP_SIM;
            3'd3:    r = REP_NONE;
            3'd4:    r = REP_CALLERID;
            3'd5:    r = REP_NONE;
            3'd6:    r = REP_CLEARED;
            default: r = REP_CONFIGURED;
        endcase
        return r;
    endfunction

endpackage

/* src/mcs_ifs.sv */
interface mcs_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_req;
    logic        send_pending;
    logic [15:0] message_handle;
    logic [7:0]  sms_index;

    modport source (output valid, event_req, send_pending, message_handle, sms_index,
                    input ready);
    modport sink (input valid, event_req, send_pending, message_handle, sms_index,
                  output ready);
endinterface

interface mcs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  issued_command;
    logic [7:0]  command_index;
    logic [15:0] payload_handle;
    logic [1:0]  timer_action;
    logic [15:0] timer_ms;
    logic [3:0]  report;
    logic        send_taken;
    logic        configured;

    modport source (output valid, mode, issued_command, command_index, payload_handle,
                    timer_action, timer_ms, report, send_taken, configured,
                    input ready);
    modport sink (input valid, mode, issued_command, command_index, payload_handle,
                  timer_action, timer_ms, report, send_taken, configured,
                  output ready);
endinterface

/* src/mcs_cfg_regs.sv */
module mcs_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output mcs_pkg::cfg_t   cfg
);
    import mcs_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reply_tmo   <= REPLY_TMO_RST;
            cfg_reg.payload_tmo <= PAYLOAD_TMO_RST;
            cfg_reg.cmd_limit   <= CMD_LIMIT_RST;
            cfg_reg.pay_limit   <= PAY_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_REPLY_TMO:   cfg_reg.reply_tmo   <= pwdata[15:0];
                REG_PAYLOAD_TMO: cfg_reg.payload_tmo <= pwdata[15:0];
                REG_CMD_LIMIT:   cfg_reg.cmd_limit   <= pwdata[2:0];
                REG_PAY_LIMIT:   cfg_reg.pay_limit   <= pwdata[2:0];
                default:         cfg_reg.reply_tmo   <= cfg_reg.reply_tmo;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_REPLY_TMO:   prdata = {16'd0, cfg_reg.reply_tmo};
            REG_PAYLOAD_TMO: prdata = {16'd0, cfg_reg.payload_tmo};
            REG_CMD_LIMIT:   prdata = {29'd0, cfg_reg.cmd_limit};
            REG_PAY_LIMIT:   prdata = {29'd0, cfg_reg.pay_limit};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

/* src/mcs_seq.sv */
module mcs_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  mcs_pkg::item_t    item,
    input  mcs_pkg::cfg_t     cfg,
    output mcs_pkg::result_t  result
);
    import mcs_pkg::*;

    logic [1:0]  mode_reg, mode_next;
    logic [4:0]  cstep_reg, cstep_next;
    logic [1:0]  rstep_reg, rstep_next;
    logic [1:0]  sstep_reg, sstep_next;
    logic [2:0]  retry_reg, retry_next;
    logic [2:0]  pretry_reg, pretry_next;
    logic        conf_reg, conf_next;
    logic [15:0] handle_reg, handle_next;

    logic [2:0]  retry_bump, pretry_bump, retry_after;
    logic        retry_give_up, pretry_give_up;
    logic [2:0]  ev;

    assign ev             = item.event_req;
    assign retry_bump     = (retry_reg == 3'd7) ? 3'd7 : retry_reg + 3'd1;
    assign pretry_bump    = (pretry_reg == 3'd7) ? 3'd7 : pretry_reg + 3'd1;
    assign retry_give_up  = retry_bump >= cfg.cmd_limit;
    assign pretry_give_up = pretry_bump >= cfg.pay_limit;
    assign retry_after    = retry_give_up ? 3'd0 : retry_bump;

    always_comb
    begin
        mode_next   = mode_reg;
        cstep_next  = cstep_reg;
        rstep_next  = rstep_reg;
        sstep_next  = sstep_reg;
        retry_next  = retry_reg;
        pretry_next = pretry_reg;
        conf_next   = conf_reg;
        handle_next = handle_reg;
        result      = '0;

        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (!conf_reg)
                    mode_next = MODE_CONFIG;
                else if (ev == EV_MSG)
                    mode_next = MODE_READ;
                else if (item.send_pending)
                begin
                    mode_next         = MODE_SEND;
                    result.send_taken = 1'b1;
                    handle_next       = item.message_handle;
                end
            end
            MODE_CONFIG:
            begin
                if (cstep_reg[4])
                    cstep_next = 5'd0;
                else if (!cstep_reg[0])
                begin
                    result.issued_command = {1'b0, cstep_reg[3:1]} + 4'd1;
                    result.timer_action   = T_START;
                    result.timer_ms       = cfg.reply_tmo;
                    cstep_next            = cstep_reg + 5'd1;
                end
                else if (ev == EV_OK)
                begin
                    result.timer_action = T_STOP;
                    retry_next          = 3'd0;
                    result.report       = cfg_report(cstep_reg[3:1]);
                    if (cstep_reg == 5'd15)
                    begin
                        conf_next  = 1'b1;
                        mode_next  = MODE_IDLE;
                        cstep_next = 5'd0;
                    end
                    else
                        cstep_next = cstep_reg + 5'd1;
                end
                else if (ev == EV_TIMEOUT)
                begin
                    result.timer_action = T_STOP;
                    retry_next          = retry_after;
                    if (retry_give_up)
                    begin
                        mode_next  = MODE_IDLE;
                        cstep_next = 5'd0;
                    end
                    else
                        cstep_next = cstep_reg - 5'd1;
                end
            end
            MODE_READ:
            begin
                if (!rstep_reg[0])
                begin
                    result.issued_command = rstep_reg[1] ? CMD_DELETE : CMD_READ;
                    result.command_index  = item.sms_index;
                    result.timer_action   = T_START;
                    result.timer_ms       = cfg.reply_tmo;
                    rstep_next            = rstep_reg + 2'd1;
                end
                else if (!rstep_reg[1])
                begin
                    if (ev == EV_TIMEOUT)
                    begin
                        result.timer_action = T_STOP;
                        retry_next          = retry_after;
                        rstep_next          = retry_give_up ? 2'd2 : 2'd0;
                    end
                    else if (ev == EV_KNOWN || ev == EV_UNKNOWN)
                    begin
                        result.timer_action = T_STOP;
                        retry_next          = 3'd0;
                    end
                    else if (ev == EV_OK)
                    begin
                        result.timer_action = T_STOP;
                        retry_next          = 3'd0;
                        rstep_next          = 2'd2;
                    end
                end
                else
                begin
                    if (ev == EV_OK)
                    begin
                        result.timer_action = T_STOP;
                        retry_next          = 3'd0;
                        result.report       = REP_DELETED;
                        mode_next           = MODE_IDLE;
                        rstep_next          = 2'd0;
                    end
                    else if (ev == EV_TIMEOUT)
                    begin
                        result.timer_action = T_STOP;
                        retry_next          = retry_after;
                        if (retry_give_up)
                        begin
                            mode_next  = MODE_IDLE;
                            rstep_next = 2'd0;
                        end
                        else
                            rstep_next = 2'd2;
                    end
                end
            end
            default:
            begin
                unique case (sstep_reg)
                    2'd0:
                    begin
                        result.issued_command = CMD_ADDRESS;
                        result.timer_action   = T_START;
                        result.timer_ms       = cfg.reply_tmo;
                        sstep_next            = 2'd1;
                    end
                    2'd1:
                    begin
                        if (ev == EV_READY)
                        begin
                            result.timer_action = T_STOP;
                            retry_next          = 3'd0;
                            sstep_next          = 2'd2;
                        end
                        else if (ev == EV_TIMEOUT)
                        begin
                            result.timer_action = T_STOP;
                            retry_next          = retry_after;
                            sstep_next          = 2'd0;
                            if (retry_give_up)
                                mode_next = MODE_IDLE;
                        end
                    end
                    2'd2:
                    begin
                        result.issued_command = CMD_PAYLOAD;
                        result.payload_handle = handle_reg;
                        result.timer_action   = T_START;
                        result.timer_ms       = cfg.payload_tmo;
                        sstep_next            = 2'd3;
                    end
                    default:
                    begin
                        if (ev == EV_OK || ev == EV_ERROR)
                        begin
                            result.timer_action = T_STOP;
                            pretry_next         = 3'd0;
                            result.report       = (ev == EV_OK) ? REP_SENT : REP_NOTSENT;
                            mode_next           = MODE_IDLE;
                            sstep_next          = 2'd0;
                        end
                        else if (ev == EV_TIMEOUT)
                        begin
                            result.timer_action = T_STOP;
                            sstep_next          = 2'd0;
                            if (pretry_give_up)
                            begin
                                pretry_next = 3'd0;
                                mode_next   = MODE_IDLE;
                            end
                            else
                                pretry_next = pretry_bump;
                        end
                    end
                endcase
            end
        endcase

        result.mode       = mode_next;
        result.configured = conf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            cstep_reg  <= 5'd0;
            rstep_reg  <= 2'd0;
            sstep_reg  <= 2'd0;
            retry_reg  <= 3'd0;
            pretry_reg <= 3'd0;
            conf_reg   <= 1'b0;
            handle_reg <= 16'd0;
        end
        else if (step_en)
        begin
            mode_reg   <= mode_next;
            cstep_reg  <= cstep_next;
            rstep_reg  <= rstep_next;
            sstep_reg  <= sstep_next;
            retry_reg  <= retry_next;
            pretry_reg <= pretry_next;
            conf_reg   <= conf_next;
            handle_reg <= handle_next;
        end
    end

endmodule

/* src/modem_command_sequencer_core.sv */
// channel   role        dir   handshake     payload
// in_ch     event word  in    valid/ready   event_req, send_pending, message_handle, sms_index
// out_ch    result word out   valid/ready   mode, command, index, handle, timer, report, flags
// apb       config      in    psel/penable  reply/payload timeouts, retry limits
//
// an accepted event word passes the input register, then the result register
// one word per cycle sustained while out_ch is ready; sequencer state updates as a word moves to the result register
// rst_n clears the sequencer to idle, unconfigured, and loads the default timeouts and limits
// a stalled result register holds the input register; an empty input register takes one word
module modem_command_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    mcs_in_if.sink      in_ch,
    mcs_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mcs_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t step_res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    mcs_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mcs_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg.event_req      <= in_ch.event_req;
            in_item_reg.send_pending   <= in_ch.send_pending;
            in_item_reg.message_handle <= in_ch.message_handle;
            in_item_reg.sms_index      <= in_ch.sms_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= step_res;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.mode           = out_reg.mode;
    assign out_ch.issued_command = out_reg.issued_command;
    assign out_ch.command_index  = out_reg.command_index;
    assign out_ch.payload_handle = out_reg.payload_handle;
    assign out_ch.timer_action   = out_reg.timer_action;
    assign out_ch.timer_ms       = out_reg.timer_ms;
    assign out_ch.report         = out_reg.report;
    assign out_ch.send_taken     = out_reg.send_taken;
    assign out_ch.configured     = out_reg.configured;

`ifndef SYNTHESIS
    a_held_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("buffered event word lost while stalled");

    a_free_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("input stalled with empty result register");

    a_cmd_starts_timer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.issued_command != CMD_NONE |-> out_reg.timer_action == T_START)
        else $error("command issued without timer start");
`endif

endmodule
